FILE: rtl/i2cste_pkg.sv
// package for the i2c slave transaction engine
// mode, status, response and register index codes, default buffer depth
// no dependencies
package i2cste_pkg;

    localparam int BUF_DEPTH_DEF = 32;

    typedef enum logic [2:0] {
        MODE_BUS   = 3'd0,
        MODE_LOAD  = 3'd1,
        MODE_READ  = 3'd2,
        MODE_TAKE  = 3'd3,
        MODE_CLEAR = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_WAIT     = 3'd0,
        ST_RECEIVED = 3'd1,
        ST_SENT     = 3'd2,
        ST_NACK     = 3'd3,
        ST_ERROR    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RSP_NONE = 2'd0,
        RSP_ACK  = 2'd1,
        RSP_NACK = 2'd2
    } t_rsp;

    typedef enum logic {
        CFG_SEND_LEN = 1'b0,
        CFG_RECV_LEN = 1'b1
    } t_cfg_reg;

endpackage

FILE: rtl/i2c_slave_transaction_engine.sv
// I2C slave transaction engine: takes one item per clock cycle, back to back,
// unless stalled. Bus events, take and clear update the link state in the cycle
// they are accepted; the result passes through the stage-one register, with the
// registered read of the send or receive store, and the output register.
// Each store is accessed at most once per item, which sets the one-item-per-cycle
// rate. The receive store reads as zero until written, tracked by one valid bit
// per entry, so no clearing pass is needed after reset. Configuration writes are
// taken at any time and must only be issued while the engine is idle.
// top level, depends on i2cste_pkg and i2cste_ram
module i2c_slave_transaction_engine #(
    parameter int BUF_DEPTH = i2cste_pkg::BUF_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [5:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_mode,
    input  logic       i_fault,
    input  logic       i_ap_flag,
    input  logic       i_ap_is_address,
    input  logic       i_master_reads,
    input  logic       i_data_flag,
    input  logic       i_master_nack,
    input  logic [7:0] i_rx_byte,
    input  logic [4:0] i_buffer_index,
    input  logic [7:0] i_buffer_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_response,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic [2:0] o_status,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_last_dir,
    output logic [5:0] o_last_length,
    output logic [7:0] o_read_byte
);

    import i2cste_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [8:0] DEPTH9 = 9'(BUF_DEPTH);

    typedef struct packed {
        t_rsp    rsp;
        logic    txv;
        logic    send_rd;
        t_status status;
        logic    busy;
        logic    done;
        logic    ldir;
        logic [5:0] llen;
        logic    recv_rd;
        logic    recv_vld;
    } t_s1;

    typedef struct packed {
        t_rsp    rsp;
        logic    txv;
        logic [7:0] tx_byte;
        t_status status;
        logic    busy;
        logic    done;
        logic    ldir;
        logic [5:0] llen;
        logic [7:0] read_byte;
    } t_out;

    logic [5:0] r_send_len, r_recv_len;
    logic       r_open, n_open;
    logic [5:0] r_pos, n_pos;
    logic       r_dir, n_dir;
    t_status    r_res, n_res;
    logic       r_pdir, n_pdir;
    logic [5:0] r_plen, n_plen;
    logic [BUF_DEPTH-1:0] r_recv_vld;

    logic       r_s1_vld;
    t_s1        r_s1, n_s1;
    logic       r_out_vld;
    t_out       r_out, n_out;

    logic       in_acc, s1_adv;
    logic       send_wr, send_rd, recv_wr, recv_rd;
    logic [8:0] send_raddr9, recv_waddr9, idx9;
    logic [AW-1:0] send_raddr, recv_waddr, idx_addr;
    logic [7:0] send_rdata, recv_rdata;

    assign o_cfg_ready = 1'b1;
    assign s1_adv  = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_s1_vld && r_out_vld && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign idx9    = {4'd0, i_buffer_index};

    always_comb begin
        logic       go;
        logic [8:0] pos9;
        go = 1'b0;
        pos9 = 9'd0;
        n_open = r_open;
        n_pos = r_pos;
        n_dir = r_dir;
        n_res = r_res;
        n_pdir = r_pdir;
        n_plen = r_plen;
        n_s1 = '0;
        send_wr = 1'b0;
        send_rd = 1'b0;
        recv_wr = 1'b0;
        recv_rd = 1'b0;
        send_raddr9 = 9'd0;
        recv_waddr9 = 9'd0;
        if (in_acc) begin
            unique case (i_mode)
                MODE_BUS: begin
                    if (r_send_len != 6'd0 && r_recv_len != 6'd0) begin
                        if (i_fault) begin
                            n_open = 1'b0;
                            n_pos = 6'd0;
                            n_res = ST_ERROR;
                        end else begin
                            go = 1'b1;
                            if (i_ap_flag) begin
                                if (r_open) begin
                                    n_pdir = r_dir;
                                    n_plen = r_pos;
                                    n_res = r_dir ? ST_SENT : ST_RECEIVED;
                                    n_s1.done = 1'b1;
                                end
                                if (!i_ap_is_address) begin
                                    n_open = 1'b0;
                                    go = 1'b0;
                                end else begin
                                    n_open = 1'b1;
                                    n_pos = 6'd0;
                                    n_dir = i_master_reads;
                                    n_s1.rsp = RSP_ACK;
                                end
                            end
                            if (go && i_data_flag) begin
                                if (i_master_reads) begin
                                    if (n_pos != 6'd0 && i_master_nack) begin
                                        n_pos = n_pos - 6'd1;
                                    end
                                    n_s1.txv = 1'b1;
                                    pos9 = {3'd0, n_pos};
                                    if (pos9 < {3'd0, r_send_len} && pos9 < DEPTH9) begin
                                        send_rd = 1'b1;
                                        send_raddr9 = pos9;
                                        n_pos = n_pos + 6'd1;
                                    end
                                end else begin
                                    pos9 = {3'd0, n_pos};
                                    if (pos9 < {3'd0, r_recv_len} && pos9 < DEPTH9) begin
                                        recv_wr = 1'b1;
                                        recv_waddr9 = pos9;
                                        n_pos = n_pos + 6'd1;
                                        n_s1.rsp = RSP_ACK;
                                    end else begin
                                        n_res = ST_NACK;
                                        n_s1.rsp = RSP_NACK;
                                    end
                                end
                            end
                        end
                    end
                end
                MODE_LOAD: begin
                    send_wr = idx9 < DEPTH9;
                end
                MODE_READ: begin
                    recv_rd = idx9 < DEPTH9;
                end
                MODE_TAKE: begin
                    if (r_res == ST_RECEIVED || r_res == ST_SENT) begin
                        n_res = ST_WAIT;
                    end
                end
                MODE_CLEAR: begin
                    n_res = ST_WAIT;
                end
                default: ;
            endcase
        end
        n_s1.send_rd = send_rd;
        n_s1.recv_rd = recv_rd;
        n_s1.status = n_res;
        n_s1.busy = n_open;
        n_s1.ldir = n_pdir;
        n_s1.llen = n_plen;
        n_s1.recv_vld = r_recv_vld[idx_addr];
    end

    assign send_raddr = send_raddr9[AW-1:0];
    assign recv_waddr = recv_waddr9[AW-1:0];
    assign idx_addr   = idx9[AW-1:0];

    i2cste_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_send_ram (
        .i_clk     (i_clk),
        .i_wr_en   (send_wr),
        .i_wr_addr (idx_addr),
        .i_wr_data (i_buffer_value),
        .i_rd_en   (send_rd),
        .i_rd_addr (send_raddr),
        .o_rd_data (send_rdata)
    );

    i2cste_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_recv_ram (
        .i_clk     (i_clk),
        .i_wr_en   (recv_wr),
        .i_wr_addr (recv_waddr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (recv_rd),
        .i_rd_addr (idx_addr),
        .o_rd_data (recv_rdata)
    );

    always_comb begin
        n_out.rsp = r_s1.rsp;
        n_out.txv = r_s1.txv;
        n_out.tx_byte = r_s1.send_rd ? send_rdata : 8'd0;
        n_out.status = r_s1.status;
        n_out.busy = r_s1.busy;
        n_out.done = r_s1.done;
        n_out.ldir = r_s1.ldir;
        n_out.llen = r_s1.llen;
        n_out.read_byte = (r_s1.recv_rd && r_s1.recv_vld) ? recv_rdata : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_len <= 6'd0;
            r_recv_len <= 6'd0;
            r_open <= 1'b0;
            r_pos <= 6'd0;
            r_dir <= 1'b0;
            r_res <= ST_WAIT;
            r_pdir <= 1'b0;
            r_plen <= 6'd0;
            r_recv_vld <= '0;
            r_s1_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_SEND_LEN: r_send_len <= i_cfg_data;
                    CFG_RECV_LEN: r_recv_len <= i_cfg_data;
                endcase
            end
            r_open <= n_open;
            r_pos <= n_pos;
            r_dir <= n_dir;
            r_res <= n_res;
            r_pdir <= n_pdir;
            r_plen <= n_plen;
            if (recv_wr) begin
                r_recv_vld[recv_waddr] <= 1'b1;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_response    = r_out.rsp;
    assign o_tx_valid    = r_out.txv;
    assign o_tx_byte     = r_out.tx_byte;
    assign o_status      = r_out.status;
    assign o_busy_res    = r_out.busy;
    assign o_done_res    = r_out.done;
    assign o_last_dir    = r_out.ldir;
    assign o_last_length = r_out.llen;
    assign o_read_byte   = r_out.read_byte;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {3'd0, r_pos} <= DEPTH9)
        else $error("position beyond buffer depth");

    a_item_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted transaction lost before ram stage");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && i_stall) |-> !in_acc)
        else $error("transaction accepted while pipeline is full");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.txv) |-> (r_out.tx_byte == 8'd0))
        else $error("tx byte set without tx valid");

endmodule

FILE: rtl/i2cste_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// read data holds while no read is issued
// no dependencies
module i2cste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench for i2c_slave_transaction_engine: directed and random transactions checked
// against an in-bench model of the link state and both buffers; depends on i2cste_pkg
module tb;
    import i2cste_pkg::*;

    localparam int DEPTH         = BUF_DEPTH_DEF;
    localparam int AW            = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic [2:0] mode;
        logic       fault;
        logic       ap_flag;
        logic       ap_is_address;
        logic       master_reads;
        logic       data_flag;
        logic       master_nack;
        logic [7:0] rx_byte;
        logic [4:0] buffer_index;
        logic [7:0] buffer_value;
    } bus_item_t;

    typedef struct packed {
        logic [1:0] response;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] status;
        logic       busy;
        logic       done;
        logic       last_dir;
        logic [5:0] last_length;
        logic [7:0] read_byte;
    } reply_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [5:0] i_cfg_data;
    logic       i_valid;
    logic       o_stall;
    logic [2:0] i_mode;
    logic       i_fault;
    logic       i_ap_flag;
    logic       i_ap_is_address;
    logic       i_master_reads;
    logic       i_data_flag;
    logic       i_master_nack;
    logic [7:0] i_rx_byte;
    logic [4:0] i_buffer_index;
    logic [7:0] i_buffer_value;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_response;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic [2:0] o_status;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_last_dir;
    logic [5:0] o_last_length;
    logic [7:0] o_read_byte;

    i2c_slave_transaction_engine uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_fault        (i_fault),
        .i_ap_flag      (i_ap_flag),
        .i_ap_is_address(i_ap_is_address),
        .i_master_reads (i_master_reads),
        .i_data_flag    (i_data_flag),
        .i_master_nack  (i_master_nack),
        .i_rx_byte      (i_rx_byte),
        .i_buffer_index (i_buffer_index),
        .i_buffer_value (i_buffer_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_response     (o_response),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_status       (o_status),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_last_dir     (o_last_dir),
        .o_last_length  (o_last_length),
        .o_read_byte    (o_read_byte)
    );

    // engine model state
    logic [5:0] send_len_m;
    logic [5:0] recv_len_m;
    logic       link_open_m;
    logic [5:0] position_m;
    logic       cur_dir_m;
    t_status    result_m;
    logic       prev_dir_m;
    logic [5:0] prev_len_m;
    logic [7:0] recv_mem [DEPTH];
    logic [7:0] send_mem [DEPTH];

    reply_t pending_replies [$];
    int     err_count;
    int     cycle_count;
    int     phase_items;
    int     send_gap_pct;
    int     stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch %s: got %0h expected %0h", what, got, want);
        err_count++;
    endtask

    function automatic logic [5:0] clamp_len(input logic [5:0] len);
        return (len > DEPTH) ? 6'(DEPTH) : len;
    endfunction

    function automatic reply_t predict_engine(input bus_item_t it);
        reply_t     r;
        logic [5:0] slen;
        logic [5:0] rlen;
        logic       go;
        r = '0;
        r.response = RSP_NONE;
        slen = clamp_len(send_len_m);
        rlen = clamp_len(recv_len_m);
        case (it.mode)
            MODE_BUS: begin
                go = (send_len_m != 0) && (recv_len_m != 0);
                if (go && it.fault) begin
                    link_open_m = 1'b0;
                    position_m  = '0;
                    result_m    = ST_ERROR;
                    go          = 1'b0;
                end
                if (go && it.ap_flag) begin
                    if (link_open_m) begin
                        prev_dir_m = cur_dir_m;
                        prev_len_m = position_m;
                        result_m   = cur_dir_m ? ST_SENT : ST_RECEIVED;
                        r.done     = 1'b1;
                    end
                    if (!it.ap_is_address) begin
                        link_open_m = 1'b0;
                        go          = 1'b0;
                    end else begin
                        link_open_m = 1'b1;
                        position_m  = '0;
                        cur_dir_m   = it.master_reads;
                        r.response  = RSP_ACK;
                    end
                end
                if (go && it.data_flag) begin
                    if (it.master_reads) begin
                        if (position_m > 0 && it.master_nack)
                            position_m = position_m - 6'd1;
                        r.tx_valid = 1'b1;
                        if (position_m < slen) begin
                            r.tx_byte  = send_mem[position_m[AW-1:0]];
                            position_m = position_m + 6'd1;
                        end
                    end else if (position_m >= rlen) begin
                        result_m   = ST_NACK;
                        r.response = RSP_NACK;
                    end else begin
                        recv_mem[position_m[AW-1:0]] = it.rx_byte;
                        position_m = position_m + 6'd1;
                        r.response = RSP_ACK;
                    end
                end
            end
            MODE_LOAD: send_mem[it.buffer_index] = it.buffer_value;
            MODE_READ: r.read_byte = recv_mem[it.buffer_index];
            MODE_TAKE: begin
                if (result_m == ST_RECEIVED || result_m == ST_SENT)
                    result_m = ST_WAIT;
            end
            MODE_CLEAR: result_m = ST_WAIT;
            default: ;
        endcase
        r.status      = result_m;
        r.busy        = link_open_m;
        r.last_dir    = prev_dir_m;
        r.last_length = prev_len_m;
        return r;
    endfunction

    task automatic check_reply();
        reply_t got;
        reply_t want;
        got.response    = o_response;
        got.tx_valid    = o_tx_valid;
        got.tx_byte     = o_tx_byte;
        got.status      = o_status;
        got.busy        = o_busy_res;
        got.done        = o_done_res;
        got.last_dir    = o_last_dir;
        got.last_length = o_last_length;
        got.read_byte   = o_read_byte;
        if (pending_replies.size() == 0) begin
            report_mismatch("result with no transaction waiting", 0, 0);
        end else begin
            want = pending_replies.pop_front();
            if (got.response !== want.response)
                report_mismatch("response", got.response, want.response);
            if (got.tx_valid !== want.tx_valid)
                report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
            if (got.tx_byte !== want.tx_byte)
                report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.busy !== want.busy)
                report_mismatch("busy_res", got.busy, want.busy);
            if (got.done !== want.done)
                report_mismatch("done_res", got.done, want.done);
            if (got.last_dir !== want.last_dir)
                report_mismatch("last_dir", got.last_dir, want.last_dir);
            if (got.last_length !== want.last_length)
                report_mismatch("last_length", got.last_length, want.last_length);
            if (got.read_byte !== want.read_byte)
                report_mismatch("read_byte", got.read_byte, want.read_byte);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            check_reply();
    end

    function automatic bus_item_t bus_ev(input logic fault, input logic ap, input logic addr,
                                         input logic rd, input logic data, input logic nack,
                                         input logic [7:0] rx);
        bus_item_t it;
        it               = bus_item_t'($urandom);
        it.mode          = MODE_BUS;
        it.fault         = fault;
        it.ap_flag       = ap;
        it.ap_is_address = addr;
        it.master_reads  = rd;
        it.data_flag     = data;
        it.master_nack   = nack;
        it.rx_byte       = rx;
        return it;
    endfunction

    function automatic bus_item_t buf_op(input logic [2:0] m, input logic [4:0] idx,
                                         input logic [7:0] val);
        bus_item_t it;
        it              = bus_item_t'($urandom);
        it.mode         = m;
        it.buffer_index = idx;
        it.buffer_value = val;
        return it;
    endfunction

    // one transaction on the input channel, with random idle cycles ahead of it
    task automatic push_event(input bus_item_t it);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= it.mode;
        i_fault         <= it.fault;
        i_ap_flag       <= it.ap_flag;
        i_ap_is_address <= it.ap_is_address;
        i_master_reads  <= it.master_reads;
        i_data_flag     <= it.data_flag;
        i_master_nack   <= it.master_nack;
        i_rx_byte       <= it.rx_byte;
        i_buffer_index  <= it.buffer_index;
        i_buffer_value  <= it.buffer_value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (it.mode <= MODE_CLEAR && (it.mode != MODE_BUS || (send_len_m != 0 && recv_len_m != 0)))
            phase_items++;
        pending_replies.push_back(predict_engine(it));
    endtask

    task automatic drain_replies();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [5:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_SEND_LEN)
            send_len_m = val;
        else
            recv_len_m = val;
    endtask

    task automatic configure_lengths(input logic [5:0] send_len, input logic [5:0] recv_len);
        drain_replies();
        write_reg(CFG_SEND_LEN, send_len);
        write_reg(CFG_RECV_LEN, recv_len);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_disabled();
        push_event(bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'hA5));
        push_event(bus_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        push_event(buf_op(MODE_READ, 5'd31, 8'h00));
        configure_lengths(6'd20, 6'd0);
        push_event(bus_ev(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
        configure_lengths(6'd0, 6'd20);
        push_event(bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h3C));
    endtask

    task automatic test_preload();
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0)
                push_event(buf_op(MODE_LOAD, 5'(i), 8'h00));
            else if (i == DEPTH - 1)
                push_event(buf_op(MODE_LOAD, 5'(i), 8'hFF));
            else
                push_event(buf_op(MODE_LOAD, 5'(i), 8'($urandom)));
        end
    endtask

    task automatic test_master_write();
        configure_lengths(6'd3, 6'd2);
        push_event(bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF));
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h5A));
        push_event(bus_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        push_event(buf_op(MODE_READ, 5'd0, 8'h00));
        push_event(buf_op(MODE_READ, 5'd1, 8'h00));
        push_event(buf_op(MODE_TAKE, 5'd0, 8'h00));
    endtask

    task automatic test_master_read();
        push_event(bus_ev(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00));
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00));
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00));
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00));
        push_event(bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        push_event(buf_op(MODE_CLEAR, 5'd0, 8'h00));
    endtask

    task automatic test_fault();
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'hC3));
        push_event(bus_ev(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        push_event(buf_op(MODE_TAKE, 5'd0, 8'h00));
        push_event(buf_op(MODE_CLEAR, 5'd0, 8'h00));
        push_event(bus_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00));
        push_event(bus_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    endtask

    task automatic test_unknown_modes();
        for (int m = MODE_CLEAR + 1; m < 8; m++)
            push_event(buf_op(3'(m), 5'($urandom), 8'($urandom)));
    endtask

    // mostly well-formed address, data, stop sequences; some buffer work and noise
    task automatic random_transaction();
        int   pick;
        int   count;
        int   ending;
        logic rd;
        pick = $urandom_range(99);
        if (pick < 10) begin
            push_event(bus_item_t'($urandom));
        end else if (pick < 25) begin
            push_event(buf_op(3'($urandom_range(MODE_CLEAR, MODE_LOAD)), 5'($urandom),
                              8'($urandom)));
        end else begin
            rd = 1'($urandom);
            count = $urandom_range(0, (rd ? clamp_len(send_len_m) : clamp_len(recv_len_m)) + 2);
            push_event(bus_ev(1'b0, 1'b1, 1'b1, rd, $urandom_range(9) == 0, 1'($urandom),
                              8'($urandom)));
            for (int i = 0; i < count; i++)
                push_event(bus_ev(1'b0, 1'b0, 1'($urandom), rd, 1'b1,
                                  $urandom_range(4) == 0, 8'($urandom)));
            ending = $urandom_range(99);
            if (ending < 55)
                push_event(bus_ev(1'b0, 1'b1, 1'b0, 1'($urandom), 1'b0, 1'b0, 8'($urandom)));
            else if (ending < 62)
                push_event(bus_ev(1'b0, 1'b1, 1'b0, 1'($urandom), 1'b1, 1'($urandom),
                                  8'($urandom)));
            else if (ending < 72)
                push_event(bus_ev(1'b1, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                                  1'($urandom), 8'($urandom)));
        end
    endtask

    task automatic test_random_traffic();
        int send_pick [4] = '{32, 1, 32, 1};
        int recv_pick [4] = '{32, 1, 1, 32};
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 4)
                configure_lengths(6'(send_pick[ph]), 6'(recv_pick[ph]));
            else
                configure_lengths(6'($urandom_range(1, DEPTH)), 6'($urandom_range(1, DEPTH)));
            case (ph % 4)
                0: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    send_gap_pct = 53;
                    stall_pct    = 0;
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct    = 53;
                end
                default: begin
                    send_gap_pct = 20;
                    stall_pct    = 20;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                random_transaction();
        end
        send_gap_pct = 0;
        stall_pct    = 0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_SEND_LEN;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_mode          <= MODE_BUS;
        i_fault         <= 1'b0;
        i_ap_flag       <= 1'b0;
        i_ap_is_address <= 1'b0;
        i_master_reads  <= 1'b0;
        i_data_flag     <= 1'b0;
        i_master_nack   <= 1'b0;
        i_rx_byte       <= '0;
        i_buffer_index  <= '0;
        i_buffer_value  <= '0;
        i_stall         <= 1'b0;
        err_count    = 0;
        cycle_count  = 0;
        phase_items  = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        send_len_m   = '0;
        recv_len_m   = '0;
        link_open_m  = 1'b0;
        position_m   = '0;
        cur_dir_m    = 1'b0;
        result_m     = ST_WAIT;
        prev_dir_m   = 1'b0;
        prev_len_m   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            recv_mem[i] = '0;
            send_mem[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled();
        test_preload();
        test_master_write();
        test_master_read();
        test_fault();
        test_unknown_modes();
        test_random_traffic();

        drain_replies();
        if (err_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
